### hw/rtl/llg_pkg.sv
// Package for the recency list with ghost list: request and result types,
// operation codes, cell shift commands, sequencer states, register indexes.
// No dependencies.
package llg_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GHOST_LIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE = 2'd2;

    typedef enum logic [1:0] {
        OP_ACCESS = 2'd0,
        OP_GHOST  = 2'd1,
        OP_EXTEND = 2'd2,
        OP_SHRINK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SH_NOP   = 2'd0,
        SH_FRONT = 2'd1,
        SH_DEL   = 2'd2
    } t_shift_op;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EXEC  = 2'd1,
        S_EVICT = 2'd2,
        S_OUT   = 2'd3
    } t_state;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key;
    } t_in_req;

    typedef struct packed {
        logic        result_flag;
        logic [15:0] use_count;
        logic [4:0]  main_size;
        logic [4:0]  ghost_fill;
        logic [4:0]  capacity_now;
    } t_out_res;

endpackage

### hw/rtl/llg_cell.sv
// One slot of a recency chain: holds a data word and a valid bit, compares
// its key, and shifts from either neighbor on command. Depends on llg_pkg.
module llg_cell #(
    parameter int IDX = 0,
    parameter int DW  = 48,
    parameter int KW  = 32,
    parameter int PW  = 5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  llg_pkg::t_shift_op     i_op,
    input  logic [PW-1:0]          i_pos,
    input  logic [PW-1:0]          i_len,
    input  logic [DW-1:0]          i_new,
    input  logic [DW-1:0]          i_prev,
    input  logic [DW-1:0]          i_next,
    input  logic [KW-1:0]          i_match_key,
    output logic [DW-1:0]          o_data,
    output logic                   o_valid,
    output logic                   o_hit
);
    import llg_pkg::*;

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [DW-1:0] r_data, n_data;
    logic          r_valid, n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        case (i_op)
            SH_FRONT: begin
                // slots up to the moved one take their left neighbor
                if (MY_IDX == '0) begin
                    n_data = i_new;
                end else if (MY_IDX <= i_pos) begin
                    n_data = i_prev;
                end
                n_valid = MY_IDX < i_len;
            end
            SH_DEL: begin
                if (MY_IDX >= i_pos) begin
                    n_data = i_next;
                end
                n_valid = MY_IDX < i_len;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;
    assign o_hit   = r_valid && (r_data[DW-1 -: KW] == i_match_key);

endmodule

### hw/rtl/lru_list_with_ghost.sv
// Recency list with ghost list: top level with the request sequencer and
// the two cell chains. Depends on llg_pkg and llg_cell.
//
// Usage: a request {op, key} enters on i_in_valid / o_in_stall; one result
// leaves per request on o_out_valid / i_out_stall from an output register.
// Ops: access, ghost check, insert-and-extend, evict-and-shrink.
// All slots compare the key in parallel; then each step moves the whole
// chain by one shift command.
// Sequence: the result is finished in the exec state for a hit, a ghost
// check, a zero-capacity access or a zero-capacity shrink; a miss, extend
// or shrink goes on to the evict state, which evicts one tail key per step
// (normally 0 or 1 keys, more after capacity was lowered) and then finishes
// the result. The next request is taken once the sequencer is back in idle.
// One request is in work at a time; o_in_stall is high from acceptance until
// the result is loaded into the output register.
// If the receiver stalls while a result is held, the next result waits in
// the block and the input stays stalled until the register frees.
// Reset (synchronous, i_rst_n low): both lists empty, capacity 8, ghost
// limit 16, promote threshold 3. Configuration writes go through
// i_cfg_we / i_cfg_idx / i_cfg_data and should only be issued while idle.
module lru_list_with_ghost #(
    parameter int MAX_ENTRIES   = 16,
    parameter int GHOST_ENTRIES = 16,
    parameter int KEY_WIDTH     = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  llg_pkg::t_in_req                   i_in_req,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output llg_pkg::t_out_res                  o_out_res,
    input  logic                               i_cfg_we,
    input  logic [llg_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [llg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import llg_pkg::*;

    localparam int MW = $clog2(MAX_ENTRIES + 1);
    localparam int GW = $clog2(GHOST_ENTRIES + 1);
    localparam int MDW = KEY_WIDTH + COUNT_W;
    localparam int CAP_RST = (8 > MAX_ENTRIES) ? MAX_ENTRIES : 8;
    localparam int LIM_RST = (16 > GHOST_ENTRIES) ? GHOST_ENTRIES : 16;

    // sequencer registers
    t_state                r_state, n_state;
    t_op                   r_op;
    logic [KEY_WIDTH-1:0]  r_key;
    logic [MW-1:0]         r_main_n, n_main_n;
    logic [GW-1:0]         r_ghost_n, n_ghost_n;
    logic [MW-1:0]         r_cap, n_cap;
    logic [GW-1:0]         r_lim;
    logic [COUNT_W-1:0]    r_thr;
    logic                  r_flag;
    logic [COUNT_W-1:0]    r_cnt;
    logic                  r_out_valid;
    t_out_res              r_out;

    // chain wiring
    logic [MAX_ENTRIES-1:0][MDW-1:0]        m_data;
    logic [MAX_ENTRIES-1:0]                 m_valid, m_hit;
    logic [GHOST_ENTRIES-1:0][KEY_WIDTH-1:0] g_data;
    logic [GHOST_ENTRIES-1:0]               g_valid, g_hit;

    t_shift_op             m_op, g_op;
    logic [MW-1:0]         m_pos, m_len;
    logic [GW-1:0]         g_pos, g_len;
    logic [MDW-1:0]        m_new;
    logic [KEY_WIDTH-1:0]  g_key;

    logic [MW-1:0]         m_hit_pos;
    logic                  m_found;
    logic [GW-1:0]         g_hit_pos;
    logic                  g_found;
    logic [COUNT_W-1:0]    hit_cnt, cnt_inc;
    logic [KEY_WIDTH-1:0]  tail_key;
    logic [GW-1:0]         g_left, g_keep, g_newlen;

    logic                  done, out_free, out_ld;
    logic                  res_flag, ld_flag;
    logic [COUNT_W-1:0]    res_cnt, ld_cnt;
    logic [4:0]            cfg5;

    genvar j;
    generate
        for (j = 0; j < MAX_ENTRIES; j++) begin : g_main
            logic [MDW-1:0] prev_d, next_d;
            if (j == 0) begin : g_first
                assign prev_d = '0;
            end else begin : g_mid
                assign prev_d = m_data[j-1];
            end
            if (j == MAX_ENTRIES - 1) begin : g_last
                assign next_d = '0;
            end else begin : g_inner
                assign next_d = m_data[j+1];
            end
            llg_cell #(.IDX(j), .DW(MDW), .KW(KEY_WIDTH), .PW(MW)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (m_op),
                .i_pos       (m_pos),
                .i_len       (m_len),
                .i_new       (m_new),
                .i_prev      (prev_d),
                .i_next      (next_d),
                .i_match_key (r_key),
                .o_data      (m_data[j]),
                .o_valid     (m_valid[j]),
                .o_hit       (m_hit[j])
            );
        end
        for (j = 0; j < GHOST_ENTRIES; j++) begin : g_ghost
            logic [KEY_WIDTH-1:0] prev_d, next_d;
            if (j == 0) begin : g_first
                assign prev_d = '0;
            end else begin : g_mid
                assign prev_d = g_data[j-1];
            end
            if (j == GHOST_ENTRIES - 1) begin : g_last
                assign next_d = '0;
            end else begin : g_inner
                assign next_d = g_data[j+1];
            end
            llg_cell #(.IDX(j), .DW(KEY_WIDTH), .KW(KEY_WIDTH), .PW(GW)) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_op        (g_op),
                .i_pos       (g_pos),
                .i_len       (g_len),
                .i_new       (g_key),
                .i_prev      (prev_d),
                .i_next      (next_d),
                .i_match_key (g_key),
                .o_data      (g_data[j]),
                .o_valid     (g_valid[j]),
                .o_hit       (g_hit[j])
            );
        end
    endgenerate

    // first hit in each chain; position equals the depth when none
    always_comb begin
        m_hit_pos = MW'(MAX_ENTRIES);
        hit_cnt   = '0;
        tail_key  = '0;
        for (int k = MAX_ENTRIES - 1; k >= 0; k--) begin
            if (m_hit[k]) begin
                m_hit_pos = MW'(k);
            end
            if (m_hit[k]) begin
                hit_cnt = hit_cnt | m_data[k][COUNT_W-1:0];
            end
            if (r_main_n == MW'(k + 1)) begin
                tail_key = tail_key | m_data[k][MDW-1 -: KEY_WIDTH];
            end
        end
        g_hit_pos = GW'(GHOST_ENTRIES);
        for (int k = GHOST_ENTRIES - 1; k >= 0; k--) begin
            if (g_hit[k]) begin
                g_hit_pos = GW'(k);
            end
        end
    end

    assign m_found = |m_hit;
    assign g_found = |g_hit;
    assign cnt_inc = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + 16'd1;

    // ghost insert: drop the equal key, trim to limit-1, add one at front
    assign g_left   = r_ghost_n - GW'(g_found);
    assign g_keep   = (g_left < r_lim - GW'(1)) ? g_left : r_lim - GW'(1);
    assign g_newlen = g_keep + GW'(1);

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state   = r_state;
        n_main_n  = r_main_n;
        n_ghost_n = r_ghost_n;
        n_cap     = r_cap;
        m_op      = SH_NOP;
        m_pos     = m_hit_pos;
        m_len     = r_main_n;
        m_new     = {r_key, 16'd1};
        g_op      = SH_NOP;
        g_pos     = g_hit_pos;
        g_len     = r_ghost_n;
        g_key     = r_key;
        done      = 1'b0;
        res_flag  = 1'b0;
        res_cnt   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_ACCESS: begin
                        if (r_cap == '0) begin
                            done = 1'b1;
                        end else if (m_found) begin
                            m_op     = SH_FRONT;
                            m_new    = {r_key, cnt_inc};
                            res_cnt  = cnt_inc;
                            res_flag = cnt_inc >= r_thr;
                            done     = 1'b1;
                        end else begin
                            n_state = S_EVICT;
                        end
                    end
                    OP_GHOST: begin
                        if (g_found) begin
                            g_op      = SH_DEL;
                            g_len     = r_ghost_n - GW'(1);
                            n_ghost_n = r_ghost_n - GW'(1);
                            res_flag  = 1'b1;
                        end
                        done = 1'b1;
                    end
                    OP_EXTEND: begin
                        if (r_cap != MW'(MAX_ENTRIES)) begin
                            n_cap = r_cap + MW'(1);
                        end
                        if (m_found) begin
                            m_op     = SH_DEL;
                            m_len    = r_main_n - MW'(1);
                            n_main_n = r_main_n - MW'(1);
                        end
                        n_state = S_EVICT;
                    end
                    OP_SHRINK: begin
                        if (r_cap == '0) begin
                            done = 1'b1;
                        end else begin
                            n_state = S_EVICT;
                        end
                    end
                    default: ;
                endcase
            end
            S_EVICT: begin
                g_key = tail_key;
                if (r_main_n != '0 && r_main_n >= r_cap) begin
                    m_op     = SH_DEL;
                    m_pos    = r_main_n - MW'(1);
                    m_len    = r_main_n - MW'(1);
                    n_main_n = r_main_n - MW'(1);
                    if (r_lim != '0) begin
                        g_op      = SH_FRONT;
                        g_len     = g_newlen;
                        n_ghost_n = g_newlen;
                    end
                end else if (r_op == OP_SHRINK) begin
                    n_cap    = r_cap - MW'(1);
                    res_flag = 1'b1;
                    done     = 1'b1;
                end else begin
                    m_op     = SH_FRONT;
                    m_pos    = MW'(MAX_ENTRIES);
                    m_len    = r_main_n + MW'(1);
                    n_main_n = r_main_n + MW'(1);
                    res_cnt  = 16'd1;
                    res_flag = r_op == OP_EXTEND;
                    done     = 1'b1;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (done) begin
            n_state = out_free ? S_IDLE : S_OUT;
        end
    end

    assign out_ld  = (done || r_state == S_OUT) && out_free;
    assign ld_flag = (r_state == S_OUT) ? r_flag : res_flag;
    assign ld_cnt  = (r_state == S_OUT) ? r_cnt : res_cnt;
    assign cfg5    = i_cfg_data[4:0];

    always_ff @(posedge i_clk) begin
        if (i_rst_n && r_state == S_IDLE && i_in_valid) begin
            r_op  <= t_op'(i_in_req.op);
            r_key <= KEY_WIDTH'(i_in_req.key);
        end
        if (done) begin
            r_flag <= res_flag;
            r_cnt  <= res_cnt;
        end
        if (out_ld) begin
            r_out.result_flag  <= ld_flag;
            r_out.use_count    <= ld_cnt;
            r_out.main_size    <= 5'(n_main_n);
            r_out.ghost_fill   <= 5'(n_ghost_n);
            r_out.capacity_now <= 5'(n_cap);
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_main_n    <= '0;
            r_ghost_n   <= '0;
            r_cap       <= MW'(CAP_RST);
            r_lim       <= GW'(LIM_RST);
            r_thr       <= 16'd3;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_main_n    <= n_main_n;
            r_ghost_n   <= n_ghost_n;
            r_cap       <= n_cap;
            r_out_valid <= out_ld || (r_out_valid && i_out_stall);
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_INIT_CAP: begin
                        r_cap <= (32'(cfg5) > 32'(MAX_ENTRIES)) ? MW'(MAX_ENTRIES)
                                                               : MW'(cfg5);
                    end
                    CFG_GHOST_LIM: begin
                        r_lim <= (32'(cfg5) > 32'(GHOST_ENTRIES)) ? GW'(GHOST_ENTRIES)
                                                                 : GW'(cfg5);
                    end
                    CFG_PROMOTE: r_thr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // size counters track the cell valid bits; main valid bits form a prefix; keys are unique in each list
    a_main_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_main_n) == $countones(m_valid))
        else $error("main size counter out of step with valid bits");
    a_ghost_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ghost_n) == $countones(g_valid))
        else $error("ghost size counter out of step with valid bits");
    a_main_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_valid & (m_valid + MAX_ENTRIES'(1))) == '0)
        else $error("main valid bits not a prefix");
    a_main_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(m_hit))
        else $error("duplicate key in main list");
    a_ghost_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(g_hit))
        else $error("duplicate key in ghost list");

endmodule
